### hdl/tptm_pkg.sv
// ----------------------------------------------------------------------------
// tptm_pkg - shared types and constants of the thermal PID migrator
// Widths of the temperature, error, integral and drive paths, the
// configuration register map and the structs passed between the units.
// ----------------------------------------------------------------------------
package tptm_pkg;

	// Core and thread counts
	localparam int CORE_COUNT   = 4;
	localparam int THREAD_COUNT = 4;
	localparam int CORE_W       = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
	localparam int THREAD_W     = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

	// Datapath widths
	localparam int TEMP_W    = 19;
	localparam int TARGET_W  = 18;
	localparam int GAIN_W    = 20;
	localparam int ERR_W     = 20;
	localparam int DER_W     = ERR_W + 1;
	localparam int SUM_W     = 40;
	localparam int SUMX_W    = SUM_W + 1;
	localparam int HALF_W    = SUM_W / 2;
	localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
	localparam int PROD_D_W  = GAIN_W + 1 + DER_W;
	localparam int PROD_IL_W = GAIN_W + HALF_W;
	localparam int PROD_IH_W = GAIN_W + 1 + HALF_W;
	localparam int ACC_W     = 62;
	localparam int FRAC_BITS = 16;
	localparam int DRIVE_W   = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 2'd3;

	localparam logic [TARGET_W-1:0] TARGET_RESET = 18'd80000;
	localparam logic [GAIN_W-1:0]   GAIN_P_RESET = 20'd65536;
	localparam logic [GAIN_W-1:0]   GAIN_I_RESET = 20'd6554;
	localparam logic [GAIN_W-1:0]   GAIN_D_RESET = 20'd655;

	// Register file contents
	typedef struct packed {
		logic [TARGET_W-1:0] setpoint;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
	} tptm_cfg_t;

	// Stage load enables driven by the pipeline control
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} tptm_adv_t;

	// Outcome of the hottest/coolest search and thread remap
	typedef struct packed {
		logic [CORE_W-1:0]   hottest;
		logic [CORE_W-1:0]   coolest;
		logic                moved;
		logic [THREAD_W-1:0] moved_thread;
		logic [CORE_W-1:0]   moved_to_core;
	} tptm_route_t;

endpackage

### hdl/tptm_sample_if.sv
// ----------------------------------------------------------------------------
// tptm_sample_if - sampling round channel
// Valid/ready channel carrying one temperature per core.
// ----------------------------------------------------------------------------
interface tptm_sample_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] temp_core0;
	logic signed [18:0] temp_core1;
	logic signed [18:0] temp_core2;
	logic signed [18:0] temp_core3;

	modport source (
		output valid, temp_core0, temp_core1, temp_core2, temp_core3,
		input  ready
	);
	modport sink (
		input  valid, temp_core0, temp_core1, temp_core2, temp_core3,
		output ready
	);
endinterface

### hdl/tptm_result_if.sv
// ----------------------------------------------------------------------------
// tptm_result_if - control result channel
// Valid/ready channel carrying the per-core drives and the migration outcome.
// ----------------------------------------------------------------------------
interface tptm_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive_core0;
	logic signed [31:0] drive_core1;
	logic signed [31:0] drive_core2;
	logic signed [31:0] drive_core3;
	logic [1:0]         hottest_index;
	logic [1:0]         coolest_index;
	logic               moved;
	logic [1:0]         moved_thread;
	logic [1:0]         moved_to_core;

	modport source (
		output valid, drive_core0, drive_core1, drive_core2, drive_core3,
		       hottest_index, coolest_index, moved, moved_thread, moved_to_core,
		input  ready
	);
	modport sink (
		input  valid, drive_core0, drive_core1, drive_core2, drive_core3,
		       hottest_index, coolest_index, moved, moved_thread, moved_to_core,
		output ready
	);
endinterface

### hdl/tptm_lane.sv
// ----------------------------------------------------------------------------
// tptm_lane - PID lane for one core
// Updates the saturating integral and previous error when a round is taken,
// then forms the drive over three more stages: split products, sum, shift
// and saturate.
// ----------------------------------------------------------------------------
module tptm_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tptm_pkg::tptm_adv_t                   adv,
	input  tptm_pkg::tptm_cfg_t                   cfg,
	input  logic signed [tptm_pkg::TEMP_W-1:0]    temp,
	output logic signed [tptm_pkg::DRIVE_W-1:0]   drive
);
	import tptm_pkg::*;

	logic signed [SUM_W-1:0]     error_sum_q;
	logic signed [ERR_W-1:0]     last_error_q;

	logic signed [ERR_W-1:0]     err_c;
	logic signed [SUMX_W-1:0]    sum_wide_c;
	logic signed [SUM_W-1:0]     sum_c;
	logic signed [DER_W-1:0]     der_c;

	logic signed [ERR_W-1:0]     err_s1;
	logic signed [DER_W-1:0]     der_s1;
	logic signed [SUM_W-1:0]     sum_s1;

	logic signed [PROD_P_W-1:0]  prod_p_s2;
	logic signed [PROD_D_W-1:0]  prod_d_s2;
	logic        [PROD_IL_W-1:0] prod_il_s2;
	logic signed [PROD_IH_W-1:0] prod_ih_s2;

	logic signed [ACC_W-1:0]     p_ext_c;
	logic signed [ACC_W-1:0]     d_ext_c;
	logic        [ACC_W-1:0]     il_ext_c;
	logic signed [ACC_W-1:0]     ih_ext_c;
	logic signed [ACC_W-1:0]     acc_s3;

	logic signed [ACC_W-1:0]     shifted_c;
	logic [ACC_W-DRIVE_W:0]      upper_c;
	logic signed [DRIVE_W-1:0]   drive_c;
	logic signed [DRIVE_W-1:0]   drive_s4;

	// Error, saturating integral and derivative of the incoming round
	always_comb begin
		err_c      = $signed({{(ERR_W-TARGET_W){1'b0}}, cfg.setpoint}) - ERR_W'(temp);
		sum_wide_c = SUMX_W'(error_sum_q) + SUMX_W'(err_c);
		if (sum_wide_c[SUMX_W-1] != sum_wide_c[SUM_W-1]) begin
			sum_c = sum_wide_c[SUMX_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
			                             : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_c = sum_wide_c[SUM_W-1:0];
		end
		der_c = DER_W'(err_c) - DER_W'(last_error_q);
	end

	// Hold the per-core controller state, advance it on each taken round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (adv.en_s1) begin
			error_sum_q  <= sum_c;
			last_error_q <= err_c;
		end
	end

	// Stage 1: terms of the round
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			err_s1 <= err_c;
			der_s1 <= der_c;
			sum_s1 <= sum_c;
		end
	end

	// Stage 2: gain products, integral split into two halves
	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			prod_p_s2  <= $signed({1'b0, cfg.gain_p}) * err_s1;
			prod_d_s2  <= $signed({1'b0, cfg.gain_d}) * der_s1;
			prod_il_s2 <= cfg.gain_i * sum_s1[HALF_W-1:0];
			prod_ih_s2 <= $signed({1'b0, cfg.gain_i}) * $signed(sum_s1[SUM_W-1:HALF_W]);
		end
	end

	// Stage 3: exact sum of the products
	always_comb begin
		p_ext_c  = ACC_W'(prod_p_s2);
		d_ext_c  = ACC_W'(prod_d_s2);
		il_ext_c = ACC_W'(prod_il_s2);
		ih_ext_c = ACC_W'(prod_ih_s2) <<< HALF_W;
	end

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			acc_s3 <= $signed(p_ext_c + d_ext_c + il_ext_c + ih_ext_c);
		end
	end

	// Stage 4: floor shift and saturate to the drive width
	always_comb begin
		shifted_c = acc_s3 >>> FRAC_BITS;
		upper_c   = shifted_c[ACC_W-1:DRIVE_W-1];
		if ((&upper_c) || !(|upper_c)) begin
			drive_c = shifted_c[DRIVE_W-1:0];
		end else begin
			drive_c = shifted_c[ACC_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
			                             : {1'b0, {(DRIVE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s4) begin
			drive_s4 <= drive_c;
		end
	end

	assign drive = drive_s4;

endmodule

### hdl/tptm_merge.sv
// ----------------------------------------------------------------------------
// tptm_merge - hottest/coolest search and thread remap
// Picks the first hottest and first coolest core of a round, then moves the
// lowest-numbered thread on the hottest core to the coolest one.
// ----------------------------------------------------------------------------
module tptm_merge (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  tptm_pkg::tptm_adv_t                                   adv,
	input  logic [tptm_pkg::CORE_COUNT-1:0][tptm_pkg::TEMP_W-1:0] temp,
	output tptm_pkg::tptm_route_t                                 route
);
	import tptm_pkg::*;

	logic [CORE_W-1:0]   thread_core_q [THREAD_COUNT];

	logic [CORE_W-1:0]   hot_c;
	logic [CORE_W-1:0]   cool_c;
	logic [CORE_W-1:0]   hot_s1;
	logic [CORE_W-1:0]   cool_s1;

	logic                found_c;
	logic [THREAD_W-1:0] sel_c;

	tptm_route_t         route_c;
	tptm_route_t         route_s2;
	tptm_route_t         route_s3;
	tptm_route_t         route_s4;

	// Find the first maximum and first minimum temperature
	always_comb begin
		hot_c  = '0;
		cool_c = '0;
		for (int c = 1; c < CORE_COUNT; c++) begin
			if ($signed(temp[c]) > $signed(temp[hot_c])) begin
				hot_c = CORE_W'(c);
			end
			if ($signed(temp[c]) < $signed(temp[cool_c])) begin
				cool_c = CORE_W'(c);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			hot_s1  <= hot_c;
			cool_s1 <= cool_c;
		end
	end

	// Lowest-numbered thread on the hottest core
	always_comb begin
		found_c = 1'b0;
		sel_c   = '0;
		for (int t = 0; t < THREAD_COUNT; t++) begin
			if (!found_c && (thread_core_q[t] == hot_s1)) begin
				found_c = 1'b1;
				sel_c   = THREAD_W'(t);
			end
		end
		route_c.hottest       = hot_s1;
		route_c.coolest       = cool_s1;
		route_c.moved         = found_c;
		route_c.moved_thread  = found_c ? sel_c : '0;
		route_c.moved_to_core = found_c ? cool_s1 : '0;
	end

	// Hold the thread map, remap as each round leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < THREAD_COUNT; t++) begin
				thread_core_q[t] <= CORE_W'(t % CORE_COUNT);
			end
		end else if (adv.en_s2 && found_c) begin
			thread_core_q[sel_c] <= cool_s1;
		end
	end

	// Carry the outcome alongside the lane pipelines
	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			route_s2 <= route_c;
		end
		if (adv.en_s3) begin
			route_s3 <= route_s2;
		end
		if (adv.en_s4) begin
			route_s4 <= route_s3;
		end
	end

	assign route = route_s4;

	a_moved_core: assert property (@(posedge clk) disable iff (!arst_n)
		adv.en_s2 && found_c |=> route_s2.moved && route_s2.moved_to_core == route_s2.coolest)
		else $error("remapped thread not sent to the coolest core");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv.en_s2 && !found_c |=> route_s2.moved_thread == '0 && route_s2.moved_to_core == '0)
		else $error("thread and core fields not cleared when nothing moved");

	a_remap: assert property (@(posedge clk) disable iff (!arst_n)
		adv.en_s2 && found_c |=> thread_core_q[$past(sel_c)] == $past(cool_s1))
		else $error("thread map not updated on remap");

endmodule

### hdl/thermal_pid_thread_migrator_unit.sv
// ----------------------------------------------------------------------------
// thermal_pid_thread_migrator_unit - per-core PID thermal control with
// hottest-to-coolest thread migration
//
//   channel   dir  handshake          contents
//   sample    in   valid/ready        temp_core0..3, signed millidegrees
//   result    out  valid/ready        drive_core0..3, hottest/coolest index,
//                                     moved, moved_thread, moved_to_core
//   cfg       in   cfg_we, no ready   cfg_index, cfg_data (4 registers)
//
// Four-stage pipeline: a taken round passes through stages 1 to 4 and is
// offered on the result channel from stage 4; a new round can be taken
// every cycle while the pipeline is not stalled, the lane state being
// updated in the cycle of acceptance.
// Each stage moves on when the next is empty or moving, so bubbles close up
// and sample.ready only drops when all four stages hold a result and
// result.ready is low.
// arst_n clears the integrals, previous errors, thread map and stage valids
// and loads the register reset values.
// ----------------------------------------------------------------------------
module thermal_pid_thread_migrator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	tptm_sample_if.sink                         sample,
	tptm_result_if.source                       result,
	input  logic                                cfg_we,
	input  logic [tptm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tptm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tptm_pkg::*;

	tptm_cfg_t                              cfg_q;
	logic                                   v_s1;
	logic                                   v_s2;
	logic                                   v_s3;
	logic                                   v_s4;
	logic                                   rdy1;
	logic                                   rdy2;
	logic                                   rdy3;
	logic                                   rdy4;
	logic                                   accept;
	tptm_adv_t                              adv;
	logic [CORE_COUNT-1:0][TEMP_W-1:0]      temp_pk;
	logic [CORE_COUNT-1:0][DRIVE_W-1:0]     drive_pk;
	tptm_route_t                            route;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= TARGET_RESET;
			cfg_q.gain_p   <= GAIN_P_RESET;
			cfg_q.gain_i   <= GAIN_I_RESET;
			cfg_q.gain_d   <= GAIN_D_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_TEMP: cfg_q.setpoint <= cfg_data[TARGET_W-1:0];
				REG_GAIN_P:      cfg_q.gain_p   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:      cfg_q.gain_i   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:      cfg_q.gain_d   <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage control: advance a stage when the next one is free or moving
	always_comb begin
		rdy4         = !v_s4 || result.ready;
		rdy3         = !v_s3 || rdy4;
		rdy2         = !v_s2 || rdy3;
		rdy1         = !v_s1 || rdy2;
		accept       = sample.valid && rdy1;
		adv.en_s1    = accept;
		adv.en_s2    = v_s1 && rdy2;
		adv.en_s3    = v_s2 && rdy3;
		adv.en_s4    = v_s3 && rdy4;
		sample.ready = rdy1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sample.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Gather the per-core temperatures
	always_comb begin
		temp_pk[0] = sample.temp_core0;
		temp_pk[1] = sample.temp_core1;
		temp_pk[2] = sample.temp_core2;
		temp_pk[3] = sample.temp_core3;
	end

	// One PID lane per core
	for (genvar c = 0; c < CORE_COUNT; c++) begin : g_lane
		tptm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.cfg    (cfg_q),
			.temp   ($signed(temp_pk[c])),
			.drive  (drive_pk[c])
		);
	end

	// Hottest/coolest search and thread remap
	tptm_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.temp   (temp_pk),
		.route  (route)
	);

	// Drive the result transaction
	always_comb begin
		result.valid         = v_s4;
		result.drive_core0   = $signed(drive_pk[0]);
		result.drive_core1   = $signed(drive_pk[1]);
		result.drive_core2   = $signed(drive_pk[2]);
		result.drive_core3   = $signed(drive_pk[3]);
		result.hottest_index = 2'(route.hottest);
		result.coolest_index = 2'(route.coolest);
		result.moved         = route.moved;
		result.moved_thread  = 2'(route.moved_thread);
		result.moved_to_core = 2'(route.moved_to_core);
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> v_s1)
		else $error("accepted transaction did not enter stage 1");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && !result.ready)
		else $error("input stalled with room in the pipeline");

	a_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy4 |=> v_s4)
		else $error("stage 3 transaction lost on its way to the output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !v_s3 |=> !result.valid)
		else $error("result repeated after it was taken");

endmodule

### verif/thermal_pid_thread_migrator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermal_pid_thread_migrator_unit_tb - self-checking bench for the thermal
// PID migrator
// Drives sampling rounds through the sample channel under random idling and
// back-pressure, predicts the per-core drives and the migration outcome of
// every accepted round, and compares each result transaction in order.
// Covers register writes at the extremes, ties, empty hottest cores, drive
// saturation and a closing stretch at full error with no idling.
// ----------------------------------------------------------------------------
module thermal_pid_thread_migrator_unit_tb;
	import tptm_pkg::*;

	localparam longint INTEG_MAX    = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint INTEG_MIN    = -INTEG_MAX - 1;
	localparam longint DRIVE_MAX    = (longint'(1) <<< (DRIVE_W - 1)) - 1;
	localparam longint DRIVE_MIN    = -DRIVE_MAX - 1;

	typedef struct packed {
		logic [CORE_COUNT-1:0][DRIVE_W-1:0] drive;
		tptm_route_t                        route;
	} round_result_t;

	typedef logic [CORE_COUNT-1:0][TEMP_W-1:0] round_temps_t;

	// Tracks the controller state and the results still owed by the block
	class pid_round_checker;
		logic [TARGET_W-1:0] setpoint;
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		longint              integral [CORE_COUNT];
		longint              prev_error [CORE_COUNT];
		logic [CORE_W-1:0]   thread_core [THREAD_COUNT];
		round_result_t       owed_results [$];
		int unsigned         failures;

		function new();
			setpoint = TARGET_RESET;
			gain_p   = GAIN_P_RESET;
			gain_i   = GAIN_I_RESET;
			gain_d   = GAIN_D_RESET;
			for (int c = 0; c < CORE_COUNT; c++) begin
				integral[c]   = 0;
				prev_error[c] = 0;
			end
			for (int t = 0; t < THREAD_COUNT; t++) begin
				thread_core[t] = CORE_W'(t % CORE_COUNT);
			end
			failures = 0;
		endfunction

		// Mirror a register write; the target keeps only its low bits
		function void write_register(logic [CFG_IDX_W-1:0] idx,
		                             logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TARGET_TEMP: setpoint = data[TARGET_W-1:0];
				REG_GAIN_P:      gain_p   = data[GAIN_W-1:0];
				REG_GAIN_I:      gain_i   = data[GAIN_W-1:0];
				REG_GAIN_D:      gain_d   = data[GAIN_W-1:0];
				default:         ;
			endcase
		endfunction

		// Advance the controller by one accepted round and queue its result
		function void note_round(round_temps_t temps);
			longint        temp [CORE_COUNT];
			longint        err;
			longint        sum;
			longint        acc;
			longint        drv;
			int            hot;
			int            cool;
			round_result_t res;
			res  = '0;
			hot  = 0;
			cool = 0;
			for (int c = 0; c < CORE_COUNT; c++) begin
				temp[c] = longint'($signed(temps[c]));
				err     = longint'(setpoint) - temp[c];
				// integral first, clamped, then the drive uses it
				sum = integral[c] + err;
				if (sum > INTEG_MAX)
					sum = INTEG_MAX;
				if (sum < INTEG_MIN)
					sum = INTEG_MIN;
				integral[c] = sum;
				acc = longint'(gain_p) * err + longint'(gain_i) * sum
				      + longint'(gain_d) * (err - prev_error[c]);
				drv = acc >>> FRAC_BITS;
				if (drv > DRIVE_MAX)
					drv = DRIVE_MAX;
				if (drv < DRIVE_MIN)
					drv = DRIVE_MIN;
				prev_error[c] = err;
				res.drive[c]  = drv[DRIVE_W-1:0];
			end
			// first maximum and first minimum
			for (int c = 1; c < CORE_COUNT; c++) begin
				if (temp[c] > temp[hot])
					hot = c;
				if (temp[c] < temp[cool])
					cool = c;
			end
			res.route.hottest = hot[CORE_W-1:0];
			res.route.coolest = cool[CORE_W-1:0];
			// move the lowest thread sitting on the hottest core
			for (int t = 0; t < THREAD_COUNT; t++) begin
				if (!res.route.moved && thread_core[t] == hot[CORE_W-1:0]) begin
					thread_core[t]          = cool[CORE_W-1:0];
					res.route.moved         = 1'b1;
					res.route.moved_thread  = t[THREAD_W-1:0];
					res.route.moved_to_core = cool[CORE_W-1:0];
				end
			end
			owed_results.push_back(res);
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
		                            logic signed [63:0] got);
			if (got !== want) begin
				failures++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		// Compare one result transaction with the oldest owed result
		function void check_round(round_result_t got);
			round_result_t want;
			if (owed_results.size() == 0) begin
				failures++;
				$error("result transaction with no round outstanding");
				return;
			end
			want = owed_results.pop_front();
			for (int c = 0; c < CORE_COUNT; c++) begin
				compare_field($sformatf("drive_core%0d", c), $signed(want.drive[c]),
				              $signed(got.drive[c]));
			end
			compare_field("hottest_index", want.route.hottest, got.route.hottest);
			compare_field("coolest_index", want.route.coolest, got.route.coolest);
			compare_field("moved", want.route.moved, got.route.moved);
			compare_field("moved_thread", want.route.moved_thread,
			              got.route.moved_thread);
			compare_field("moved_to_core", want.route.moved_to_core,
			              got.route.moved_to_core);
		endfunction
	endclass

	typedef enum int {
		BIAS_MIXED,
		BIAS_HOT,
		BIAS_COLD,
		BIAS_SOAK
	} temp_bias_e;

	localparam int TEMP_MAX    = (1 << (TEMP_W - 1)) - 1;
	localparam int TEMP_MIN    = -(1 << (TEMP_W - 1));
	localparam int SOAK_ROUNDS = 60;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit                    tx_idle;
	bit                    rx_idle;
	int unsigned           hold_request;
	pid_round_checker      rounds;

	tptm_sample_if sample ();
	tptm_result_if result ();

	thermal_pid_thread_migrator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Draw one round of temperatures with the requested bias
	function automatic round_temps_t random_temps(temp_bias_e bias);
		round_temps_t temps;
		int           v;
		int           pick;
		for (int c = 0; c < CORE_COUNT; c++) begin
			case (bias)
				BIAS_HOT:  v = TEMP_MAX - int'($urandom_range(0, 4095));
				BIAS_COLD: v = TEMP_MIN + int'($urandom_range(0, 4095));
				BIAS_SOAK: v = TEMP_MIN + int'($urandom_range(0, 63));
				default: begin
					pick = $urandom_range(0, 9);
					if (pick < 7)
						v = int'($urandom_range(0, 190000)) - 40000;
					else if (pick < 9)
						v = int'($urandom());
					else
						v = $urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN;
				end
			endcase
			temps[c] = v[TEMP_W-1:0];
		end
		// force ties now and then
		if (bias != BIAS_SOAK && $urandom_range(0, 7) == 0)
			temps[$urandom_range(0, CORE_COUNT - 1)] = temps[$urandom_range(0, CORE_COUNT - 1)];
		return temps;
	endfunction

	// Offer one round and hold it until the block takes it
	task automatic send_round(round_temps_t temps);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample.valid      <= 1'b1;
		sample.temp_core0 <= temps[0];
		sample.temp_core1 <= temps[1];
		sample.temp_core2 <= temps[2];
		sample.temp_core3 <= temps[3];
		do @(posedge clk); while (!sample.ready);
		rounds.note_round(temps);
	endtask

	task automatic send4(int t0, int t1, int t2, int t3);
		round_temps_t temps;
		temps[0] = t0[TEMP_W-1:0];
		temps[1] = t1[TEMP_W-1:0];
		temps[2] = t2[TEMP_W-1:0];
		temps[3] = t3[TEMP_W-1:0];
		send_round(temps);
	endtask

	task automatic run_phase(int count, temp_bias_e bias);
		for (int i = 0; i < count; i++) begin
			send_round(random_temps(bias));
		end
	endtask

	// Drop valid and hold until every owed result has come back
	task automatic wait_drained();
		sample.valid <= 1'b0;
		do @(posedge clk); while (rounds.pending() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		rounds.write_register(idx, data);
	endtask

	// Rewrite all four registers while the block is idle
	task automatic apply_settings(logic [CFG_DATA_W-1:0] target, logic [CFG_DATA_W-1:0] kp,
	                              logic [CFG_DATA_W-1:0] ki, logic [CFG_DATA_W-1:0] kd);
		wait_drained();
		write_reg(REG_TARGET_TEMP, target);
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		cfg_we <= 1'b0;
	endtask

	// Accept and check results, with random and requested stalls
	initial begin : result_sink
		round_result_t got;
		int unsigned   stall_left;
		int unsigned   hold_left;
		result.ready = 1'b0;
		stall_left   = 0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				got.drive[0]            = result.drive_core0;
				got.drive[1]            = result.drive_core1;
				got.drive[2]            = result.drive_core2;
				got.drive[3]            = result.drive_core3;
				got.route.hottest       = result.hottest_index;
				got.route.coolest       = result.coolest_index;
				got.route.moved         = result.moved;
				got.route.moved_thread  = result.moved_thread;
				got.route.moved_to_core = result.moved_to_core;
				rounds.check_round(got);
			end
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left == 0 && stall_left == 0 && rx_idle && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 6);
			if (hold_left != 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Main sequence
	initial begin : stimulus
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		sample.valid      = 1'b0;
		sample.temp_core0 = '0;
		sample.temp_core1 = '0;
		sample.temp_core2 = '0;
		sample.temp_core3 = '0;
		tx_idle           = 1'b0;
		rx_idle           = 1'b0;
		hold_request      = 0;
		rounds            = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// equal temperatures, then an empty hottest core on the repeat
		send4(0, 0, 0, 0);
		send4(0, 0, 0, 100);
		send4(0, 0, 0, 100);
		send4(TEMP_MIN, TEMP_MAX, TEMP_MIN, TEMP_MAX);
		send4(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX);
		send4(TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN);
		send4(-40000, 150000, 150000, -40000);
		send4(5, 9, 9, 5);
		send4(9, 5, 5, 9);
		send4(174762, -174763, 174762, -174763);
		send4(-1, 1, -1, 1);
		send4(80000, 80000, 80000, 80000);
		send4(100, 200, 300, 400);
		send4(400, 300, 200, 100);

		// top bits of the target write are dropped
		apply_settings({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
		               {CFG_DATA_W{1'b1}});
		send4(TEMP_MIN, TEMP_MIN, TEMP_MAX, 0);
		send4(TEMP_MAX, TEMP_MIN, TEMP_MIN, TEMP_MAX);
		send4(0, TEMP_MAX, 0, TEMP_MIN);
		apply_settings('0, '0, '0, '0);
		send4(TEMP_MAX, 0, TEMP_MIN, 1);
		send4(TEMP_MIN, TEMP_MAX, 0, -1);
		apply_settings(CFG_DATA_W'(TARGET_RESET), CFG_DATA_W'(GAIN_P_RESET),
		               CFG_DATA_W'(GAIN_I_RESET), CFG_DATA_W'(GAIN_D_RESET));
		send4(90000, 70000, 80000, 85000);

		// random rounds at reset gains, with a long receiver hold-off
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		run_phase(220, BIAS_MIXED);
		hold_request = 64;
		run_phase(30, BIAS_MIXED);
		wait_drained();
		run_phase(20, BIAS_MIXED);

		// drive the integrals far negative, then far positive
		rx_idle = 1'b0;
		apply_settings('0, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
		run_phase(650, BIAS_HOT);
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		apply_settings({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
		               {CFG_DATA_W{1'b1}});
		run_phase(650, BIAS_COLD);

		// random settings, zero integral and derivative gains among them
		tx_idle = 1'b1;
		apply_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), '0, '0);
		run_phase(100, BIAS_MIXED);
		apply_settings(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
		               CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
		run_phase(150, BIAS_MIXED);

		// close at full error with no idling on either side
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		apply_settings({CFG_DATA_W{1'b1}}, CFG_DATA_W'(GAIN_P_RESET),
		               CFG_DATA_W'(GAIN_I_RESET), CFG_DATA_W'(GAIN_D_RESET));
		run_phase(SOAK_ROUNDS, BIAS_SOAK);

		wait_drained();
		repeat (8) @(posedge clk);
		if (rounds.failures == 0)
			$display("thermal_pid_thread_migrator_unit_tb OK");
		else
			$display("thermal_pid_thread_migrator_unit_tb NOT OK");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#100_000_000;
		$display("thermal_pid_thread_migrator_unit_tb NOT OK");
		$finish;
	end

endmodule
